### rtl/ibus_frame_receiver_top_defines.svh
// Assertion macros shared by the checker files of the receiver.
`ifndef IBUS_FRAME_RECEIVER_TOP_DEFINES_SVH
`define IBUS_FRAME_RECEIVER_TOP_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define IBFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define IBFR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/ibfr_pkg.sv
// Shared types, constants and helpers of the i-BUS frame receiver.
package ibfr_pkg;

    localparam int FRAME_BYTES  = 32;
    localparam int NUM_CHANNELS = 6;
    localparam int OUT_CHANNELS = 6;
    localparam int CSUM_SPAN    = 30;
    localparam int THR_CHANNEL  = 2;

    localparam int IDX_W        = $clog2(FRAME_BYTES);
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_END       = 2 + 2 * NUM_CHANNELS;
    localparam int CH_LIMIT     = (CH_END < CSUM_SPAN) ? CH_END : CSUM_SPAN;
    localparam int OUT_W        = 16 * OUT_CHANNELS;

    localparam logic [IDX_W-1:0] IDX_CH_FIRST = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_CH_LIMIT = IDX_W'(CH_LIMIT);
    localparam logic [IDX_W-1:0] IDX_SPAN     = IDX_W'(CSUM_SPAN);
    localparam logic [IDX_W-1:0] IDX_CSUM_LO  = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] IDX_CSUM_HI  = IDX_W'(FRAME_BYTES - 1);

    localparam logic [7:0]  HEADER_BYTE = 8'h20;
    localparam logic [15:0] CSUM_INIT   = 16'hFFFF;
    localparam logic [15:0] CH_DEFAULT  = 16'd1500;
    localparam logic [15:0] THR_DEFAULT = 16'd1000;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [15:0] chan_t;

    typedef enum logic [1:0] {
        OP_CH_LO,
        OP_CH_HI,
        OP_END
    } op_t;

    // One queue entry: a channel byte to store, or the end of a frame with its status.
    typedef struct packed {
        op_t             op;
        logic [CH_W-1:0] ch;
        logic [7:0]      data;
    } q_item_t;

    function automatic chan_t ch_reset(int i);
        return (i == THR_CHANNEL) ? THR_DEFAULT : CH_DEFAULT;
    endfunction

    function automatic logic [OUT_W-1:0] default_out();
        logic [OUT_W-1:0] v;
        v = '0;
        for (int j = 0; j < OUT_CHANNELS; j++) begin
            if (j < NUM_CHANNELS) begin
                v[j*16 +: 16] = ch_reset(j);
            end
        end
        return v;
    endfunction

endpackage

### rtl/ibus_frame_receiver_top.sv
// Top level of the i-BUS receiver frame decoder.
//
// The s_ channel takes one received serial byte per transfer. Bytes are
// dropped until a 0x20 header opens a 32-byte frame. After the last byte of
// each frame the m_ channel carries one transfer: m_tuser is the status
// (0 accepted, 1 checksum mismatch) and m_tdata the six held channels,
// updated from the frame only when its checksum is good.
// Throughput is one byte per cycle; s_tready stays high as long as the
// four-entry operation queue between the front and back ends has room.
// The frame's end passes through the queue into the result register that
// drives m_tvalid, once that register is free. While m_tready is
// low the result is held, and the queue absorbs channel bytes; when the
// queue fills, s_tready drops.
// Reset returns to hunting, empties the queue, clears m_tvalid and sets
// the held channels to 1500, with the throttle channel at 1000.
module ibus_frame_receiver_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // roll, pitch, throttle, yaw, aux_a, aux_b channels, 16 bits each
    output logic [ibfr_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tuser    // frame_status
);

    ibfr_pkg::q_item_t  push_item;
    ibfr_pkg::q_item_t  pop_item;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    ibfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    ibfr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    ibfr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (pop_item),
        .empty     (q_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/ibfr_front.sv
// Front end: frame hunting, byte position tracking and checksum check.
module ibfr_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,
    input  logic                     q_full,
    output logic                     push,
    output ibfr_pkg::q_item_t        push_item
);

    logic                         in_frame_reg, in_frame_next;
    logic [ibfr_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [15:0]                  csum_reg, csum_next;
    logic [7:0]                   lo_reg, lo_next;
    logic [ibfr_pkg::IDX_W-1:0]   ch_off;
    logic                         accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign ch_off   = idx_reg - ibfr_pkg::IDX_CH_FIRST;

    always_comb begin
        in_frame_next = in_frame_reg;
        idx_next      = idx_reg;
        csum_next     = csum_reg;
        lo_next       = lo_reg;
        push          = 1'b0;
        push_item     = '0;
        push_item.op  = ibfr_pkg::OP_CH_LO;
        if (accept) begin
            if (!in_frame_reg) begin
                if (s_tdata == ibfr_pkg::HEADER_BYTE) begin
                    in_frame_next = 1'b1;
                    idx_next      = ibfr_pkg::IDX_W'(1);
                    csum_next     = ibfr_pkg::CSUM_INIT - {8'h00, s_tdata};
                end
            end else begin
                if (idx_reg < ibfr_pkg::IDX_SPAN) begin
                    csum_next = csum_reg - {8'h00, s_tdata};
                end
                if (idx_reg >= ibfr_pkg::IDX_CH_FIRST && idx_reg < ibfr_pkg::IDX_CH_LIMIT) begin
                    push           = 1'b1;
                    push_item.op   = idx_reg[0] ? ibfr_pkg::OP_CH_HI : ibfr_pkg::OP_CH_LO;
                    push_item.ch   = ibfr_pkg::CH_W'(ch_off >> 1);
                    push_item.data = s_tdata;
                end
                if (idx_reg == ibfr_pkg::IDX_CSUM_LO) begin
                    lo_next = s_tdata;
                end
                if (idx_reg == ibfr_pkg::IDX_CSUM_HI) begin
                    // The received word is compared with the checksum of bytes 0 to 29.
                    push           = 1'b1;
                    push_item.op   = ibfr_pkg::OP_END;
                    push_item.data = {7'b0, ({s_tdata, lo_reg} != csum_reg)};
                    in_frame_next  = 1'b0;
                    idx_next       = '0;
                    csum_next      = ibfr_pkg::CSUM_INIT;
                end else begin
                    idx_next = idx_reg + ibfr_pkg::IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            idx_reg      <= '0;
            csum_reg     <= ibfr_pkg::CSUM_INIT;
        end else begin
            in_frame_reg <= in_frame_next;
            idx_reg      <= idx_next;
            csum_reg     <= csum_next;
        end
        lo_reg <= lo_next;
    end

endmodule

### rtl/ibfr_fifo.sv
// Short queue of decoded operations between the front and back ends.
module ibfr_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ibfr_pkg::q_item_t   push_item,
    output logic                full,
    input  logic                pop,
    output ibfr_pkg::q_item_t   pop_item,
    output logic                empty
);

    ibfr_pkg::q_item_t          mem_reg [ibfr_pkg::Q_DEPTH];
    logic [ibfr_pkg::Q_AW-1:0]  wr_ptr_reg;
    logic [ibfr_pkg::Q_AW-1:0]  rd_ptr_reg;
    logic [ibfr_pkg::Q_AW:0]    count_reg, count_next;

    assign full     = (count_reg == (ibfr_pkg::Q_AW+1)'(ibfr_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (ibfr_pkg::Q_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (ibfr_pkg::Q_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + ibfr_pkg::Q_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + ibfr_pkg::Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/ibfr_back.sv
// Back end: channel assembly, held channel update and the result register.
module ibfr_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ibfr_pkg::q_item_t            item,
    input  logic                         empty,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ibfr_pkg::OUT_W-1:0]   m_tdata,
    output logic                         m_tuser
);

    ibfr_pkg::chan_t               pending_reg [ibfr_pkg::NUM_CHANNELS];
    ibfr_pkg::chan_t               held_reg    [ibfr_pkg::NUM_CHANNELS];
    logic                          out_valid_reg;
    logic                          out_status_reg;
    logic [ibfr_pkg::OUT_W-1:0]    out_data_reg;
    logic [ibfr_pkg::OUT_W-1:0]    out_data_next;
    logic                          out_free;
    logic                          take_end;
    logic                          good;

    assign out_free = !out_valid_reg || m_tready;
    // An end of frame waits for the result register; channel bytes never wait.
    assign pop      = !empty && ((item.op != ibfr_pkg::OP_END) || out_free);
    assign take_end = pop && (item.op == ibfr_pkg::OP_END);
    assign good     = (item.data[0] == ibfr_pkg::STATUS_GOOD);

    for (genvar j = 0; j < ibfr_pkg::OUT_CHANNELS; j++) begin : g_out
        if (j < ibfr_pkg::NUM_CHANNELS) begin : g_live
            assign out_data_next[j*16 +: 16] = good ? pending_reg[j] : held_reg[j];
        end else begin : g_zero
            assign out_data_next[j*16 +: 16] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && item.op == ibfr_pkg::OP_CH_LO) begin
            pending_reg[item.ch][7:0] <= item.data;
        end
        if (pop && item.op == ibfr_pkg::OP_CH_HI) begin
            pending_reg[item.ch][15:8] <= item.data;
        end
        if (take_end) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= item.data[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ibfr_pkg::NUM_CHANNELS; i++) begin
                held_reg[i] <= ibfr_pkg::ch_reset(i);
            end
        end else begin
            if (take_end) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (take_end && good) begin
                for (int i = 0; i < ibfr_pkg::NUM_CHANNELS; i++) begin
                    held_reg[i] <= pending_reg[i];
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

### rtl/ibfr_checker.sv
// Port-level checker of the frame receiver and its bind to the top level.
`include "ibus_frame_receiver_top_defines.svh"

module ibfr_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [ibfr_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        m_tuser
);

    logic [ibfr_pkg::OUT_W-1:0] last_reg;
    logic                       stalled;
    logic                       in_wait;

    // Tracks the channels of the last delivered result, starting from the reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= ibfr_pkg::default_out();
        end else if (m_tvalid && m_tready) begin
            last_reg <= m_tdata;
        end
    end

    assign stalled = m_tvalid && !m_tready;
    assign in_wait = s_tvalid && !s_tready;

    `IBFR_ASSERT(a_out_hold, stalled |=> m_tvalid, "result dropped while stalled")
    `IBFR_ASSERT(a_out_stable, stalled |=> $stable(m_tdata) && $stable(m_tuser), "result changed")
    `IBFR_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid && s_tready, "not idle after reset")
    `IBFR_ASSERT(a_bad_keeps, m_tvalid && m_tuser |-> m_tdata == last_reg, "channels changed")
    `IBFR_ASSERT(a_in_hold, in_wait |=> s_tvalid && $stable(s_tdata), "input withdrawn")

endmodule

bind ibus_frame_receiver_top ibfr_checker u_checker (.*);
